// File: rtl/core/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared constants and beat types of the line pixel stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Screen geometry and coordinate format
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;
  localparam int COORD_BITS    = 13;

  // Internal widths
  localparam int POS_W   = 15;             // current point, signed
  localparam int DELTA_W = COORD_BITS + 1; // signed endpoint difference
  localparam int ABS_W   = COORD_BITS;     // absolute delta / step count
  localparam int ERR_W   = 15;             // stored doubled error
  localparam int SUM_W   = ERR_W + 1;      // error after adding 2*minor
  localparam int IDX_W   = 20;
  localparam int COLOR_W = 32;

  // Request kinds
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_kind_t;

  // Request beat
  typedef struct packed {
    req_kind_t                     req_type;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic        [COLOR_W-1:0]     line_color;
  } req_t;

  // Result beat
  typedef struct packed {
    logic               pixel_valid;
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] pixel_color;
    logic               line_done;
  } pix_t;

endpackage

// File: rtl/core/lps_req_if.sv
// ----------------------------------------------------------------------------
// lps_req_if
// Request channel: valid/ready handshake with load or step payload.
// ----------------------------------------------------------------------------
interface lps_req_if import lps_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [COORD_BITS-1:0]  start_x;
  logic signed [COORD_BITS-1:0]  start_y;
  logic signed [COORD_BITS-1:0]  end_x;
  logic signed [COORD_BITS-1:0]  end_y;
  logic        [COLOR_W-1:0]     line_color;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, line_color,
                  output ready);
endinterface

// File: rtl/core/lps_pix_if.sv
// ----------------------------------------------------------------------------
// lps_pix_if
// Result channel: valid/ready handshake with one framebuffer pixel.
// ----------------------------------------------------------------------------
interface lps_pix_if import lps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               pixel_valid;
  logic [IDX_W-1:0]   pixel_index;
  logic [COLOR_W-1:0] pixel_color;
  logic               line_done;

  modport source (output valid, pixel_valid, pixel_index, pixel_color, line_done,
                  input ready);
  modport sink   (input valid, pixel_valid, pixel_index, pixel_color, line_done,
                  output ready);
endinterface

// File: rtl/core/lps_step_core.sv
// ----------------------------------------------------------------------------
// lps_step_core
// Line state and the one-step update: load setup, major/minor stepping with
// the doubled error, on-screen test and framebuffer index.
// ----------------------------------------------------------------------------
module lps_step_core import lps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  req_t req,
  output pix_t res
);

  localparam logic signed [POS_W-1:0] COL_MAX = POS_W'(SCREEN_WIDTH - 1);
  localparam logic signed [POS_W-1:0] ROW_MAX = POS_W'(SCREEN_HEIGHT - 1);
  localparam logic signed [POS_W-1:0] COL_LIM = POS_W'(SCREEN_WIDTH);
  localparam logic signed [POS_W-1:0] ROW_LIM = POS_W'(SCREEN_HEIGHT);
  localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(1);

  // Line state
  logic signed [POS_W-1:0] cur_col, cur_col_next;
  logic signed [POS_W-1:0] cur_row, cur_row_next;
  logic                    col_step_negative, col_step_negative_next;
  logic                    row_step_negative, row_step_negative_next;
  logic                    major_is_col, major_is_col_next;
  logic [ABS_W-1:0]        major_delta, major_delta_next;
  logic [ABS_W-1:0]        minor_delta, minor_delta_next;
  logic [ERR_W-1:0]        doubled_error, doubled_error_next;
  logic [ABS_W-1:0]        steps_left, steps_left_next;
  logic [COLOR_W-1:0]      held_color, held_color_next;

  // Load setup terms
  logic signed [POS_W-1:0]   sx, sy;
  logic signed [DELTA_W-1:0] dx, dy;
  logic [ABS_W-1:0]          ax, ay;
  logic                      x_major;

  // Step terms
  logic signed [POS_W-1:0] cstep, rstep;
  logic [SUM_W-1:0]        err_sum, twice_major;
  logic                    minor_move;
  logic signed [POS_W-1:0] step_col, step_row;
  logic                    on_screen;
  logic [31:0]             idx_full;

  always_comb begin
    // load: sign-extend endpoints, deltas from the unclamped start
    sx = POS_W'(req.start_x);
    sy = POS_W'(req.start_y);
    dx = DELTA_W'(req.end_x) - DELTA_W'(req.start_x);
    dy = DELTA_W'(req.end_y) - DELTA_W'(req.start_y);
    ax = dx[DELTA_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    ay = dy[DELTA_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    x_major = ax > ay;

    // step: major axis always moves, minor axis on error overflow
    cstep = col_step_negative ? -POS_ONE : POS_ONE;
    rstep = row_step_negative ? -POS_ONE : POS_ONE;
    err_sum     = SUM_W'(doubled_error) + SUM_W'({minor_delta, 1'b0});
    twice_major = SUM_W'({major_delta, 1'b0});
    minor_move  = err_sum >= twice_major;
    step_col = (major_is_col || minor_move) ? cur_col + cstep : cur_col;
    step_row = (!major_is_col || minor_move) ? cur_row + rstep : cur_row;

    on_screen = !step_col[POS_W-1] && (step_col < COL_LIM) &&
                !step_row[POS_W-1] && (step_row < ROW_LIM);
    idx_full  = 32'(unsigned'(step_row)) * 32'(SCREEN_WIDTH) + 32'(unsigned'(step_col));

    // hold by default
    cur_col_next           = cur_col;
    cur_row_next           = cur_row;
    col_step_negative_next = col_step_negative;
    row_step_negative_next = row_step_negative;
    major_is_col_next      = major_is_col;
    major_delta_next       = major_delta;
    minor_delta_next       = minor_delta;
    doubled_error_next     = doubled_error;
    steps_left_next        = steps_left;
    held_color_next        = held_color;
    res                    = '0;

    if (req.req_type == REQ_LOAD) begin
      cur_col_next           = sx[POS_W-1] ? '0 : ((sx > COL_MAX) ? COL_MAX : sx);
      cur_row_next           = sy[POS_W-1] ? '0 : ((sy > ROW_MAX) ? ROW_MAX : sy);
      col_step_negative_next = !(dx > 0);
      row_step_negative_next = !(dy > 0);
      major_is_col_next      = x_major;
      major_delta_next       = x_major ? ax : ay;
      minor_delta_next       = x_major ? ay : ax;
      doubled_error_next     = ERR_W'(major_delta_next);
      steps_left_next        = major_delta_next;
      held_color_next        = req.line_color;
      res.line_done          = (major_delta_next == '0);
    end else if (steps_left == '0) begin
      // exhausted line: nothing moves
      res.line_done = 1'b1;
    end else begin
      cur_col_next       = step_col;
      cur_row_next       = step_row;
      doubled_error_next = minor_move ? ERR_W'(err_sum - twice_major) : ERR_W'(err_sum);
      steps_left_next    = steps_left - 1'b1;
      res.line_done      = (steps_left_next == '0);
      if (on_screen) begin
        res.pixel_valid = 1'b1;
        res.pixel_index = idx_full[IDX_W-1:0];
        res.pixel_color = held_color;
      end
    end
  end

  // State registers, updated once per accepted request beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col           <= '0;
      cur_row           <= '0;
      col_step_negative <= 1'b0;
      row_step_negative <= 1'b0;
      major_is_col      <= 1'b0;
      major_delta       <= '0;
      minor_delta       <= '0;
      doubled_error     <= '0;
      steps_left        <= '0;
      held_color        <= '0;
    end else if (take) begin
      cur_col           <= cur_col_next;
      cur_row           <= cur_row_next;
      col_step_negative <= col_step_negative_next;
      row_step_negative <= row_step_negative_next;
      major_is_col      <= major_is_col_next;
      major_delta       <= major_delta_next;
      minor_delta       <= minor_delta_next;
      doubled_error     <= doubled_error_next;
      steps_left        <= steps_left_next;
      held_color        <= held_color_next;
    end
  end

`ifndef SYNTHESIS
  // remaining steps never exceed the major delta
  a_steps_bounded: assert property (@(posedge clk) disable iff (rst)
    steps_left <= major_delta)
    else $error("steps_left exceeds major_delta");

  // error stays below twice the major delta while steps remain
  a_err_bounded: assert property (@(posedge clk) disable iff (rst)
    (steps_left != '0) |-> (SUM_W'(doubled_error) < SUM_W'({major_delta, 1'b0})))
    else $error("doubled_error out of range");

  // a step on an exhausted line leaves the point alone
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (take && req.req_type == REQ_STEP && steps_left == '0) |=>
      ($stable(cur_col) && $stable(cur_row) && steps_left == '0))
    else $error("point moved after line end");

  // every live step counts down by exactly one
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (take && req.req_type == REQ_STEP && steps_left != '0) |=>
      (steps_left == $past(steps_left) - 1'b1))
    else $error("step count did not decrement");
`endif

endmodule

// File: rtl/core/lps_out_reg.sv
// ----------------------------------------------------------------------------
// lps_out_reg
// Result register: holds one result beat until taken, and refills in the
// same cycle that the held beat leaves.
// ----------------------------------------------------------------------------
module lps_out_reg import lps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  pix_t d,
  output logic can_load,
  output logic valid,
  input  logic ready,
  output pix_t q
);

  // free when empty or when the held beat is taken now
  assign can_load = !valid || ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

// File: rtl/core/line_pixel_stepper.sv
// ----------------------------------------------------------------------------
// line_pixel_stepper
// Line rasterizer: a load beat sets up a line, step beats walk its pixels.
// ----------------------------------------------------------------------------
// With pix.ready high, one request beat is taken per clock and gives
// exactly one result beat in the following cycle, so a line of N steps
// streams out at one pixel per clock. The rate is set by the update of the
// point and doubled error in the step core; the result register lets a new
// request enter in the same cycle that the held result is taken. Load beats
// give line_done high when the line has no steps; off-screen pixels come out
// with pixel_valid low and still count toward the line length.
// ----------------------------------------------------------------------------
module line_pixel_stepper import lps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lps_req_if.sink   req,
  lps_pix_if.source pix
);

  req_t req_beat;
  pix_t step_res;
  pix_t out_beat;
  logic take;
  logic can_load;

  // pack the request beat
  always_comb begin
    req_beat.req_type   = req_kind_t'(req.req_type);
    req_beat.start_x    = req.start_x;
    req_beat.start_y    = req.start_y;
    req_beat.end_x      = req.end_x;
    req_beat.end_y      = req.end_y;
    req_beat.line_color = req.line_color;
  end

  assign req.ready = can_load;
  assign take      = req.valid && can_load;

  lps_step_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (req_beat),
    .res  (step_res)
  );

  lps_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .d        (step_res),
    .can_load (can_load),
    .valid    (pix.valid),
    .ready    (pix.ready),
    .q        (out_beat)
  );

  // unpack the result beat
  assign pix.pixel_valid = out_beat.pixel_valid;
  assign pix.pixel_index = out_beat.pixel_index;
  assign pix.pixel_color = out_beat.pixel_color;
  assign pix.line_done   = out_beat.line_done;

endmodule
